// ----- rtl/core/gbn_pkg.sv -----
// Shared constants, codes and types of the Go-Back-N sender.
`default_nettype none
package gbn_pkg;

	// Default window geometry.
	localparam int WINDOW_SIZE_DEF = 4;
	localparam int SEQ_SPACE_DEF   = 8;

	// Fixed field widths of the channels.
	localparam int PAYLOAD_W = 64;
	localparam int OP_W      = 2;
	localparam int ACK_W     = 4;
	localparam int STATUS_W  = 2;
	localparam int PSEQ_W    = 3;
	localparam int TIMER_W   = 2;
	localparam int ACK_CODES = 2 ** ACK_W;

	// Operation codes of an input beat.
	localparam logic [OP_W-1:0] OP_SEND    = 2'd0;
	localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
	localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

	// Status codes of a result beat.
	localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NOTHING = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_BAD_CK  = 2'd3;

	// Timer commands.
	localparam logic [TIMER_W-1:0] TMR_NONE    = 2'd0;
	localparam logic [TIMER_W-1:0] TMR_RESTART = 2'd1;
	localparam logic [TIMER_W-1:0] TMR_STOP    = 2'd2;

	// Read-side control of the packet store.
	typedef struct packed {
		logic replay;
		logic start;
		logic advance;
	} gbn_rd_ctl_t;

	// One result beat.
	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic                 packet_valid;
		logic [PSEQ_W-1:0]    packet_seq;
		logic [PAYLOAD_W-1:0] packet_data;
		logic [TIMER_W-1:0]   timer_cmd;
		logic                 last;
	} gbn_res_t;

	// Nonnegative remainder of a small value, used only to build constant tables.
	function automatic int seq_wrap(input int v, input int m);
		int r;
		r = v;
		for (int i = 0; i < 64; i++) begin
			if (r < 0) begin
				r = r + m;
			end else if (r >= m) begin
				r = r - m;
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/gbn_if.sv -----
// Valid/ready channel interfaces of the Go-Back-N sender.
`default_nettype none
interface gbn_cmd_if;
	import gbn_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         op;
	logic [PAYLOAD_W-1:0]    payload;
	logic signed [ACK_W-1:0] ack_number;
	logic                    ack_checksum_ok;

	modport source (output valid, op, payload, ack_number, ack_checksum_ok, input ready);
	modport sink (input valid, op, payload, ack_number, ack_checksum_ok, output ready);
endinterface

interface gbn_res_if;
	import gbn_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic                 packet_valid;
	logic [PSEQ_W-1:0]    packet_seq;
	logic [PAYLOAD_W-1:0] packet_data;
	logic [TIMER_W-1:0]   timer_cmd;
	logic                 last;

	modport source (output valid, status, packet_valid, packet_seq, packet_data, timer_cmd,
		last, input ready);
	modport sink (input valid, status, packet_valid, packet_seq, packet_data, timer_cmd,
		last, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/go_back_n_sender.sv -----
// Top level of the Go-Back-N sender window.
`default_nettype none
// Go-Back-N sender. Each command beat is a send, an acknowledgement or a timer
// expiry, and produces result beats on the res channel, the final one marked by
// last. A send, an acknowledgement, and a timeout with nothing outstanding each
// give one beat; an unused op code is taken and gives no beat. A timeout with N
// packets outstanding gives N beats, oldest first, at one beat per cycle while
// res is ready: the store first reads the oldest entry, then the beats go out
// in turn (N is at most SEQ_SPACE - 1). The beat rate is set by the single
// read port of the packet store, which delivers one stored payload per cycle;
// cmd.ready is low for the whole replay. The result beat sits in an output
// register, and a new command is taken in the cycle that register drains.
// The store has no reset: an entry is only meaningful once a send has written it.
module go_back_n_sender #(
	parameter int WINDOW_SIZE = gbn_pkg::WINDOW_SIZE_DEF,
	parameter int SEQ_SPACE   = gbn_pkg::SEQ_SPACE_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	gbn_cmd_if.sink    cmd,
	gbn_res_if.source  res
);
	import gbn_pkg::*;

	localparam int SEQ_W  = (SEQ_SPACE > 2) ? $clog2(SEQ_SPACE) : 1;
	localparam int SEQ_W1 = SEQ_W + 1;
	localparam int W_MOD  = WINDOW_SIZE % SEQ_SPACE;

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_REPLAY = 1'b1;

	logic              state_q;
	logic [SEQ_W-1:0]  window_base_q;
	logic [SEQ_W-1:0]  next_seq_q;
	logic [SEQ_W-1:0]  remain_q;
	logic              first_q;
	logic              out_vld_q;
	gbn_res_t          out_q;

	// New base for every acknowledgement code, worked out at elaboration.
	logic [SEQ_W-1:0]  ack_base_tbl [ACK_CODES];
	for (genvar g = 0; g < ACK_CODES; g++) begin : g_ack
		assign ack_base_tbl[g] = SEQ_W'(seq_wrap(
			((g >= ACK_CODES / 2) ? g - ACK_CODES : g) + 1, SEQ_SPACE));
	end

	logic              out_free;
	logic              accept;
	logic              win_empty;
	logic              win_full;
	logic [SEQ_W1-1:0] full_sum;
	logic [SEQ_W-1:0]  full_at;
	logic [SEQ_W1-1:0] diff_w;
	logic [SEQ_W-1:0]  outstanding;
	logic [SEQ_W-1:0]  next_inc;
	logic [ACK_W-1:0]  ack_idx;
	logic [SEQ_W-1:0]  ack_base;

	logic              load;
	gbn_res_t          load_res;
	logic              store_wr;
	gbn_rd_ctl_t       rd_ctl;
	logic [SEQ_W-1:0]  rd_ptr;
	logic [PAYLOAD_W-1:0] rd_data;

	// A command is taken only between replays and when the output register is
	// empty or being emptied in this cycle.
	assign out_free  = !out_vld_q || res.ready;
	assign cmd.ready = (state_q == ST_IDLE) && out_free;
	assign accept    = cmd.valid && cmd.ready;

	// Window bookkeeping. The window is full when next_seq has reached
	// base + WINDOW_SIZE modulo the sequence space.
	assign win_empty = (window_base_q == next_seq_q);
	assign full_sum  = {1'b0, window_base_q} + SEQ_W1'(W_MOD);
	assign full_at   = (full_sum >= SEQ_W1'(SEQ_SPACE)) ?
		SEQ_W'(full_sum - SEQ_W1'(SEQ_SPACE)) : full_sum[SEQ_W-1:0];
	assign win_full  = (next_seq_q == full_at);

	assign diff_w      = {1'b0, next_seq_q} - {1'b0, window_base_q};
	assign outstanding = diff_w[SEQ_W] ? SEQ_W'(diff_w + SEQ_W1'(SEQ_SPACE))
		: diff_w[SEQ_W-1:0];
	assign next_inc    = (next_seq_q == SEQ_W'(SEQ_SPACE - 1)) ? '0
		: next_seq_q + SEQ_W'(1);

	assign ack_idx  = cmd.ack_number;
	assign ack_base = ack_base_tbl[ack_idx];

	// Decide what, if anything, goes into the output register this cycle, and
	// drive the packet store.
	always_comb begin
		load      = 1'b0;
		load_res  = '0;
		store_wr  = 1'b0;
		rd_ctl    = '0;
		rd_ctl.replay = (state_q == ST_REPLAY);
		if (state_q == ST_REPLAY) begin
			if (out_free) begin
				load                  = 1'b1;
				load_res.status       = STAT_DONE;
				load_res.packet_valid = 1'b1;
				load_res.packet_seq   = PSEQ_W'(rd_ptr);
				load_res.packet_data  = rd_data;
				load_res.timer_cmd    = first_q ? TMR_RESTART : TMR_NONE;
				load_res.last         = (remain_q == SEQ_W'(1));
				rd_ctl.advance        = 1'b1;
			end
		end else if (accept) begin
			unique case (cmd.op)
				OP_SEND: begin
					load          = 1'b1;
					load_res.last = 1'b1;
					if (win_full) begin
						load_res.status = STAT_FULL;
					end else begin
						store_wr              = 1'b1;
						load_res.status       = STAT_DONE;
						load_res.packet_valid = 1'b1;
						load_res.packet_seq   = PSEQ_W'(next_seq_q);
						load_res.packet_data  = cmd.payload;
						load_res.timer_cmd    = win_empty ? TMR_RESTART : TMR_NONE;
					end
				end
				OP_ACK: begin
					load          = 1'b1;
					load_res.last = 1'b1;
					if (win_empty) begin
						load_res.status = STAT_NOTHING;
					end else if (!cmd.ack_checksum_ok) begin
						load_res.status = STAT_BAD_CK;
					end else begin
						load_res.status    = STAT_DONE;
						load_res.timer_cmd = (ack_base == next_seq_q) ? TMR_STOP
							: TMR_RESTART;
					end
				end
				OP_TIMEOUT: begin
					if (win_empty) begin
						load               = 1'b1;
						load_res.status    = STAT_DONE;
						load_res.timer_cmd = TMR_RESTART;
						load_res.last      = 1'b1;
					end else begin
						// The store reads the base entry at this edge, so the
						// first replayed beat is ready in the next cycle.
						rd_ctl.start = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			window_base_q <= '0;
			next_seq_q    <= '0;
			remain_q      <= '0;
			first_q       <= 1'b0;
			out_vld_q     <= 1'b0;
		end else begin
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end

			if (store_wr) begin
				next_seq_q <= next_inc;
			end

			if (accept && (cmd.op == OP_ACK) && !win_empty && cmd.ack_checksum_ok) begin
				window_base_q <= ack_base;
			end

			if (rd_ctl.start) begin
				state_q  <= ST_REPLAY;
				remain_q <= outstanding;
				first_q  <= 1'b1;
			end else if (rd_ctl.advance) begin
				remain_q <= remain_q - SEQ_W'(1);
				first_q  <= 1'b0;
				if (remain_q == SEQ_W'(1)) begin
					state_q <= ST_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= load_res;
		end
	end

	gbn_store #(
		.SEQ_SPACE (SEQ_SPACE)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (rd_ctl),
		.wr_en   (store_wr),
		.wr_addr (next_seq_q),
		.wr_data (cmd.payload),
		.base    (window_base_q),
		.ptr     (rd_ptr),
		.rd_data (rd_data)
	);

	assign res.valid        = out_vld_q;
	assign res.status       = out_q.status;
	assign res.packet_valid = out_q.packet_valid;
	assign res.packet_seq   = out_q.packet_seq;
	assign res.packet_data  = out_q.packet_data;
	assign res.timer_cmd    = out_q.timer_cmd;
	assign res.last         = out_q.last;

endmodule
`default_nettype wire

// ----- rtl/core/gbn_store.sv -----
// Packet store memory with its replay read cursor.
`default_nettype none
module gbn_store #(
	parameter int SEQ_SPACE = gbn_pkg::SEQ_SPACE_DEF,
	localparam int SEQ_W = (SEQ_SPACE > 2) ? $clog2(SEQ_SPACE) : 1
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire gbn_pkg::gbn_rd_ctl_t         ctl,
	input  wire logic                         wr_en,
	input  wire logic [SEQ_W-1:0]             wr_addr,
	input  wire logic [gbn_pkg::PAYLOAD_W-1:0] wr_data,
	input  wire logic [SEQ_W-1:0]             base,
	output logic      [SEQ_W-1:0]             ptr,
	output logic      [gbn_pkg::PAYLOAD_W-1:0] rd_data
);
	import gbn_pkg::*;

	logic [PAYLOAD_W-1:0] mem [SEQ_SPACE];
	logic [SEQ_W-1:0]     ptr_q;
	logic [SEQ_W-1:0]     ptr_inc;
	logic [SEQ_W-1:0]     rd_addr;
	logic [PAYLOAD_W-1:0] rd_data_q;

	assign ptr_inc = (ptr_q == SEQ_W'(SEQ_SPACE - 1)) ? '0 : ptr_q + SEQ_W'(1);

	// The read port looks one entry ahead when the cursor moves, so replayed beats
	// see fresh data every cycle in which the cursor advances.
	always_comb begin
		if (ctl.advance) begin
			rd_addr = ptr_inc;
		end else if (ctl.replay) begin
			rd_addr = ptr_q;
		end else begin
			rd_addr = base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (ctl.start) begin
			ptr_q <= base;
		end else if (ctl.advance) begin
			ptr_q <= ptr_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign ptr     = ptr_q;
	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// ----- rtl/core/gbn_checker.sv -----
// Port-level checks of the Go-Back-N sender and their binding to the top level.
`default_nettype none
module gbn_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              cmd_ready,
	input wire logic                              res_valid,
	input wire logic                              res_ready,
	input wire logic [gbn_pkg::STATUS_W-1:0]      res_status,
	input wire logic                              res_packet_valid,
	input wire logic [gbn_pkg::PSEQ_W-1:0]        res_packet_seq,
	input wire logic [gbn_pkg::PAYLOAD_W-1:0]     res_packet_data,
	input wire logic [gbn_pkg::TIMER_W-1:0]       res_timer_cmd,
	input wire logic                              res_last
);
	import gbn_pkg::*;

	// A stalled result beat keeps its status, sequence number, data and last flag.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_status)
			&& $stable(res_packet_seq) && $stable(res_packet_data) && $stable(res_last))
		else $error("result beat changed while stalled");

	// A beat without a packet carries zero sequence number and data.
	a_no_pkt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_packet_valid |-> res_packet_seq == '0 && res_packet_data == '0)
		else $error("packet fields set on a beat without a packet");

	// Any refusal is a single beat that carries no packet and leaves the timer alone.
	a_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != STAT_DONE |-> res_last && !res_packet_valid
			&& res_timer_cmd == TMR_NONE)
		else $error("malformed refusal beat");

	// New commands are taken only when the pending result leaves in the same cycle.
	a_cmd_vs_res: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready && res_valid |-> res_ready)
		else $error("command taken while a result is stalled");

endmodule

bind go_back_n_sender gbn_checker u_gbn_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_ready        (cmd.ready),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_status       (res.status),
	.res_packet_valid (res.packet_valid),
	.res_packet_seq   (res.packet_seq),
	.res_packet_data  (res.packet_data),
	.res_timer_cmd    (res.timer_cmd),
	.res_last         (res.last)
);
`default_nettype wire

// ----- tb/go_back_n_sender_tb.sv -----
// Self-checking testbench of the Go-Back-N sender window.
`timescale 1ns / 100ps

module go_back_n_sender_tb;
	import gbn_pkg::*;

	// Window geometry as built into the instance below.
	localparam int WIN  = WINDOW_SIZE_DEF;
	localparam int SEQS = SEQ_SPACE_DEF;

	// The op code that the block must take and ignore.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// Cycles without any beat on either channel before the run is abandoned.
	// The slowest correct stretch is a seven-beat replay under a 46 percent
	// receiver stall, far below this figure.
	localparam int WATCHDOG_LIMIT = 4000;

	// Cycles to wait after the last expected beat, to catch stray output.
	localparam int TAIL_CYCLES = 20;

	logic clk;
	logic arst_n;

	gbn_cmd_if cmd ();
	gbn_res_if res ();

	go_back_n_sender i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res)
	);

	// Shadow of the sender window, kept in step with every accepted command beat.
	int                   win_base;
	int                   next_seq;
	logic [PAYLOAD_W-1:0] sent_words [SEQS];
	bit                   word_written [SEQS];

	// Result beats predicted but not yet seen, oldest first.
	gbn_res_t pending_res [$];

	int errors;
	int n_cmds;
	int n_beats;
	int n_replays;
	int snd_idle_pct;
	int rcv_stall_pct;
	int quiet_cycles;

	// Clock, 20 ns period.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Every input of the block starts at a known value.
	initial begin
		arst_n          = 1'b0;
		cmd.valid       = 1'b0;
		cmd.op          = OP_SEND;
		cmd.payload     = '0;
		cmd.ack_number  = '0;
		cmd.ack_checksum_ok = 1'b0;
		res.ready       = 1'b0;
	end

	// Number of packets sent and not yet acknowledged.
	function automatic int outstanding();
		return (next_seq + SEQS - win_base) % SEQS;
	endfunction

	// A replay may only touch store entries that a send has written.
	function automatic bit replay_safe();
		int cnt;
		cnt = outstanding();
		for (int i = 0; i < cnt; i++) begin
			if (!word_written[(win_base + i) % SEQS]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// Works out the result beats of one accepted command beat and advances the
	// shadow window exactly as the sender is meant to.
	function automatic void predict_window(input logic [OP_W-1:0] op,
		input logic [PAYLOAD_W-1:0] pl, input logic signed [ACK_W-1:0] ack, input logic ck);
		gbn_res_t r;
		int       cnt;
		int       idx;
		int       nb;
		r      = '0;
		r.last = 1'b1;
		case (op)
			OP_SEND: begin
				if (next_seq == (win_base + WIN) % SEQS) begin
					r.status = STAT_FULL;
				end else begin
					sent_words[next_seq]   = pl;
					word_written[next_seq] = 1'b1;
					r.packet_valid = 1'b1;
					r.packet_seq   = next_seq[PSEQ_W-1:0];
					r.packet_data  = pl;
					r.timer_cmd    = (win_base == next_seq) ? TMR_RESTART : TMR_NONE;
					next_seq       = (next_seq + 1) % SEQS;
				end
				pending_res.push_back(r);
			end
			OP_ACK: begin
				if (win_base == next_seq) begin
					// Nothing outstanding wins over a bad checksum.
					r.status = STAT_NOTHING;
				end else if (!ck) begin
					r.status = STAT_BAD_CK;
				end else begin
					// The base follows the ack number even outside the window;
					// negative numbers wrap to a nonnegative remainder.
					nb = (int'(ack) + 1) % SEQS;
					if (nb < 0) begin
						nb = nb + SEQS;
					end
					win_base    = nb;
					r.timer_cmd = (win_base == next_seq) ? TMR_STOP : TMR_RESTART;
				end
				pending_res.push_back(r);
			end
			OP_TIMEOUT: begin
				cnt = outstanding();
				if (cnt == 0) begin
					r.timer_cmd = TMR_RESTART;
					pending_res.push_back(r);
				end else begin
					n_replays += cnt;
					idx = win_base;
					for (int i = 0; i < cnt; i++) begin
						r.packet_valid = 1'b1;
						r.packet_seq   = idx[PSEQ_W-1:0];
						r.packet_data  = sent_words[idx];
						r.timer_cmd    = (i == 0) ? TMR_RESTART : TMR_NONE;
						r.last         = (i + 1 == cnt);
						pending_res.push_back(r);
						idx = (idx + 1) % SEQS;
					end
				end
			end
			default: begin
				// The unused op code is taken silently.
			end
		endcase
	endfunction

	// Sends one command beat. Called at a falling edge, returns at the falling
	// edge after the beat was taken, with valid still high.
	task automatic send_cmd(input logic [OP_W-1:0] op, input logic [PAYLOAD_W-1:0] pl,
		input logic signed [ACK_W-1:0] ack, input logic ck);
		cmd.valid           <= 1'b1;
		cmd.op              <= op;
		cmd.payload         <= pl;
		cmd.ack_number      <= ack;
		cmd.ack_checksum_ok <= ck;
		do begin
			@(posedge clk);
		end while (!cmd.ready);
		predict_window(op, pl, ack, ck);
		n_cmds++;
		@(negedge clk);
	endtask

	// Drops valid for the given number of cycles.
	task automatic sender_gap(input int cycles);
		cmd.valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Holds the sender back until every predicted beat has come out.
	task automatic wait_drained();
		sender_gap(1);
		while (pending_res.size() != 0) begin
			@(negedge clk);
		end
	endtask

	function automatic logic [PAYLOAD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Receiver side: ready toggles at the falling edge with the current stall rate.
	always @(negedge clk) begin
		if (rcv_stall_pct == 0) begin
			res.ready <= 1'b1;
		end else begin
			res.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
		end
	end

	function automatic void check_field(input string name, input logic [PAYLOAD_W-1:0] want,
		input logic [PAYLOAD_W-1:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			errors++;
		end
	endfunction

	// Each result beat is compared with the oldest prediction.
	always @(posedge clk) begin
		gbn_res_t want;
		if (arst_n && res.valid && res.ready) begin
			n_beats++;
			if (pending_res.size() == 0) begin
				$error("result beat with no prediction waiting: status %0d seq %0d",
					res.status, res.packet_seq);
				errors++;
			end else begin
				want = pending_res.pop_front();
				check_field("status", PAYLOAD_W'(want.status), PAYLOAD_W'(res.status));
				check_field("packet_valid", PAYLOAD_W'(want.packet_valid),
					PAYLOAD_W'(res.packet_valid));
				check_field("packet_seq", PAYLOAD_W'(want.packet_seq),
					PAYLOAD_W'(res.packet_seq));
				check_field("packet_data", want.packet_data, res.packet_data);
				check_field("timer_cmd", PAYLOAD_W'(want.timer_cmd),
					PAYLOAD_W'(res.timer_cmd));
				check_field("last", PAYLOAD_W'(want.last), PAYLOAD_W'(res.last));
			end
		end
	end

	// Watchdog: too long without any beat on either channel means a hang.
	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (res.valid && res.ready) || !arst_n) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d beats outstanding", pending_res.size());
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Straight after reset: acknowledgements with nothing outstanding, even with a
	// bad checksum, an idle timeout, and the unused op code.
	task automatic test_empty_window();
		send_cmd(OP_ACK, rand_word(), 4'sd0, 1'b1);
		send_cmd(OP_ACK, rand_word(), 4'sd3, 1'b0);
		send_cmd(OP_TIMEOUT, rand_word(), 4'sd0, 1'b1);
		send_cmd(OP_UNUSED, rand_word(), 4'sd0, 1'b1);
	endtask

	// Fills the window with extreme and random payloads, then one send is refused
	// and a bad checksum leaves the window alone.
	task automatic test_window_full();
		send_cmd(OP_SEND, '0, 4'sd0, 1'b0);
		send_cmd(OP_SEND, '1, 4'sd0, 1'b1);
		for (int i = 2; i <= WIN; i++) begin
			send_cmd(OP_SEND, rand_word(), 4'sd0, 1'b0);
		end
		send_cmd(OP_ACK, rand_word(), 4'sd1, 1'b0);
	endtask

	// Replay of a full window, then a partial acknowledgement.
	task automatic test_replay();
		send_cmd(OP_TIMEOUT, '0, 4'sd0, 1'b0);
		send_cmd(OP_ACK, '0, 4'sd1, 1'b1);
	endtask

	// Acks that empty the window, wrap from -1, do not move the base, or land
	// outside the window, followed by a replay of the stretch that results.
	task automatic test_ack_wrap();
		send_cmd(OP_SEND, rand_word(), 4'sd0, 1'b1);
		send_cmd(OP_SEND, rand_word(), 4'sd0, 1'b1);
		send_cmd(OP_ACK, '0, 4'sd5, 1'b1);
		send_cmd(OP_SEND, rand_word(), 4'sd0, 1'b1);
		send_cmd(OP_SEND, rand_word(), 4'sd0, 1'b1);
		send_cmd(OP_ACK, '1, -4'sd1, 1'b1);
		send_cmd(OP_SEND, rand_word(), 4'sd0, 1'b1);
		send_cmd(OP_ACK, '0, 4'sd7, 1'b1);
		send_cmd(OP_ACK, '0, 4'sd4, 1'b1);
		send_cmd(OP_SEND, rand_word(), 4'sd0, 1'b1);
		send_cmd(OP_TIMEOUT, rand_word(), 4'sd0, 1'b1);
		send_cmd(OP_ACK, '0, 4'sd0, 1'b1);
		wait_drained();
	endtask

	// Random traffic, mostly a well-behaved sender and receiver with random
	// content, plus noise: stray ack numbers, bad checksums, unused op codes.
	task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
		int                   pick;
		int                   cnt;
		int                   ack_val;
		logic [OP_W-1:0]      op;
		logic signed [ACK_W-1:0] ack;
		logic                 ck;
		snd_idle_pct  = idle_pct;
		rcv_stall_pct = stall_pct;
		for (int i = 0; i < n_items; i++) begin
			if (snd_idle_pct != 0 && $urandom_range(0, 99) < snd_idle_pct) begin
				sender_gap($urandom_range(1, 3));
			end
			if ($urandom_range(0, 39) == 0) begin
				wait_drained();
			end
			cnt  = outstanding();
			pick = $urandom_range(0, 99);
			ck   = 1'($urandom_range(0, 1));
			ack_val = $urandom_range(0, 8) - 1;
			if (pick < 45) begin
				op = OP_SEND;
			end else if (pick < 70) begin
				// Acknowledge one of the outstanding packets, or repeat the last ack.
				op = OP_ACK;
				ck = ($urandom_range(0, 9) != 0);
				ack_val = (win_base + $urandom_range(0, cnt) + SEQS - 1) % SEQS;
				if (ack_val == SEQS - 1 && $urandom_range(0, 1)) begin
					ack_val = -1;
				end
			end else if (pick < 85) begin
				op = OP_TIMEOUT;
			end else if (pick < 95) begin
				op = OP_ACK;
			end else begin
				op = OP_UNUSED;
			end
			if (op == OP_TIMEOUT && !replay_safe()) begin
				op = OP_SEND;
			end
			ack = ack_val[ACK_W-1:0];
			send_cmd(op, rand_word(), ack, ck);
		end
		wait_drained();
	endtask

	initial begin
		errors        = 0;
		n_cmds        = 0;
		n_beats       = 0;
		n_replays     = 0;
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		quiet_cycles  = 0;
		win_base      = 0;
		next_seq      = 0;
		for (int i = 0; i < SEQS; i++) begin
			word_written[i] = 1'b0;
			sent_words[i]   = '0;
		end

		// Reset is held from time zero and released at a falling edge.
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_window();
		test_window_full();
		test_replay();
		test_ack_wrap();

		// Random traffic under four idling patterns.
		test_random(70, 0, 0);
		test_random(70, 46, 0);
		test_random(70, 0, 46);
		test_random(70, 23, 23);

		while (pending_res.size() != 0) begin
			@(negedge clk);
		end
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Covered %0d command beats and %0d result beats, %0d of them in replays",
			n_cmds, n_beats, n_replays);
		$display("under full, refused, wrapped and out-of-window traffic with random stalls.");
		if (errors == 0 && pending_res.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
